### hw/rtl/isf_pkg.sv
// ----------------------------------------------------------------------------
// isf_pkg
// Types and codes shared by the INVITE server transaction block.
// ----------------------------------------------------------------------------
package isf_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned CodeW  = 10;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    PhStart      = 3'd0,
    PhProceeding = 3'd1,
    PhCompleted  = 3'd2,
    PhConfirmed  = 3'd3,
    PhTerminated = 3'd4
  } phase_e;

  localparam logic [OpW-1:0] OpInvite   = 3'd0;
  localparam logic [OpW-1:0] OpAck      = 3'd1;
  localparam logic [OpW-1:0] OpResponse = 3'd2;
  localparam logic [OpW-1:0] OpError    = 3'd3;
  localparam logic [OpW-1:0] OpCancel   = 3'd4;
  localparam logic [OpW-1:0] OpTick     = 3'd5;

  localparam logic [CfgIdxW-1:0] CfgUnreliable = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRetxInit   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRetxCap    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAckWait    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAckAbsorb  = 3'd4;

  localparam logic [CodeW-1:0] CodeMin       = 10'd100;
  localparam logic [CodeW-1:0] CodeSuccess   = 10'd200;
  localparam logic [CodeW-1:0] CodeFinal     = 10'd300;
  localparam logic [CodeW-1:0] CodeMax       = 10'd699;

  localparam logic [TimerW-1:0] RetxInitRst  = 16'd500;
  localparam logic [TimerW-1:0] RetxCapRst   = 16'd4000;
  localparam logic [TimerW-1:0] AckWaitRst   = 16'd32000;
  localparam logic [TimerW-1:0] AckAbsorbRst = 16'd5000;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [CodeW-1:0] status_code;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] phase;
    logic       forward_to_dialog;
    logic       send_new_response;
    logic       resend_last_response;
    logic       report_error_to_dialog;
    logic       report_terminated;
  } out_item_t;

  typedef struct packed {
    logic              unreliable_transport;
    logic [TimerW-1:0] retransmit_initial_ms;
    logic [TimerW-1:0] retransmit_cap_ms;
    logic [TimerW-1:0] ack_wait_ms;
    logic [TimerW-1:0] ack_absorb_ms;
  } cfg_t;

  typedef struct packed {
    logic              have_response;
    logic [TimerW-1:0] retx_interval;
    logic [TimerW-1:0] retx_remaining;
    logic              retx_running;
    logic [TimerW-1:0] giveup_remaining;
    logic              giveup_running;
    logic [TimerW-1:0] absorb_remaining;
    logic              absorb_running;
  } timers_t;

endpackage

### hw/rtl/isf_step.sv
// ----------------------------------------------------------------------------
// isf_step
// Next phase, timer update and action flags for one event.
// ----------------------------------------------------------------------------
module isf_step (
  input  isf_pkg::phase_e    phase_i,
  input  isf_pkg::timers_t   tmr_i,
  input  isf_pkg::cfg_t      cfg_i,
  input  isf_pkg::in_item_t  item_i,
  output isf_pkg::phase_e    phase_o,
  output isf_pkg::timers_t   tmr_o,
  output isf_pkg::out_item_t res_o
);

  logic                      code_ok;
  logic                      code_final;
  logic                      code_success;
  logic                      g_fire;
  logic                      h_fire;
  logic                      i_fire;
  logic [isf_pkg::TimerW:0]  dbl;
  logic [isf_pkg::TimerW-1:0] next_ivl;

  assign code_ok      = (item_i.status_code >= isf_pkg::CodeMin) &&
                        (item_i.status_code <= isf_pkg::CodeMax);
  assign code_final   = item_i.status_code >= isf_pkg::CodeFinal;
  assign code_success = item_i.status_code >= isf_pkg::CodeSuccess;
  assign g_fire = tmr_i.retx_running   && (tmr_i.retx_remaining   <= 16'd1);
  assign h_fire = tmr_i.giveup_running && (tmr_i.giveup_remaining <= 16'd1);
  assign i_fire = tmr_i.absorb_running && (tmr_i.absorb_remaining <= 16'd1);
  assign dbl      = {tmr_i.retx_interval, 1'b0};
  assign next_ivl = (dbl > {1'b0, cfg_i.retransmit_cap_ms}) ?
                    cfg_i.retransmit_cap_ms : dbl[isf_pkg::TimerW-1:0];

  // next phase
  always_comb begin
    phase_o = phase_i;
    if (item_i.op == isf_pkg::OpCancel) begin
      phase_o = isf_pkg::PhTerminated;
    end else begin
      unique case (phase_i)
        isf_pkg::PhStart: begin
          if (item_i.op == isf_pkg::OpInvite) phase_o = isf_pkg::PhProceeding;
        end
        isf_pkg::PhProceeding: begin
          if (item_i.op == isf_pkg::OpResponse && code_ok) begin
            if (code_final) phase_o = isf_pkg::PhCompleted;
            else if (code_success) phase_o = isf_pkg::PhTerminated;
          end else if (item_i.op == isf_pkg::OpError) begin
            phase_o = isf_pkg::PhTerminated;
          end
        end
        isf_pkg::PhCompleted: begin
          if (item_i.op == isf_pkg::OpAck) phase_o = isf_pkg::PhConfirmed;
          else if (item_i.op == isf_pkg::OpError) phase_o = isf_pkg::PhTerminated;
          else if (item_i.op == isf_pkg::OpTick && h_fire) phase_o = isf_pkg::PhTerminated;
        end
        isf_pkg::PhConfirmed: begin
          if (item_i.op == isf_pkg::OpTick && i_fire) phase_o = isf_pkg::PhTerminated;
        end
        default: ;
      endcase
    end
  end

  // timers and actions
  always_comb begin
    tmr_o = tmr_i;
    res_o = '0;
    if (item_i.op == isf_pkg::OpCancel) begin
      res_o.accepted = 1'b1;
    end else begin
      unique case (phase_i)
        isf_pkg::PhStart: begin
          if (item_i.op == isf_pkg::OpInvite) begin
            res_o.accepted          = 1'b1;
            res_o.forward_to_dialog = 1'b1;
          end
        end
        isf_pkg::PhProceeding: begin
          if (item_i.op == isf_pkg::OpInvite) begin
            res_o.accepted             = 1'b1;
            res_o.resend_last_response = tmr_i.have_response;
          end else if (item_i.op == isf_pkg::OpResponse && code_ok) begin
            res_o.accepted          = 1'b1;
            res_o.send_new_response = 1'b1;
            tmr_o.have_response     = 1'b1;
            if (code_final) begin
              if (cfg_i.unreliable_transport) begin
                tmr_o.retx_interval  = cfg_i.retransmit_initial_ms;
                tmr_o.retx_remaining = cfg_i.retransmit_initial_ms;
                tmr_o.retx_running   = 1'b1;
              end
              tmr_o.giveup_remaining = cfg_i.ack_wait_ms;
              tmr_o.giveup_running   = 1'b1;
            end else if (code_success) begin
              res_o.report_terminated = 1'b1;
            end
          end else if (item_i.op == isf_pkg::OpError) begin
            res_o.accepted               = 1'b1;
            res_o.report_error_to_dialog = 1'b1;
            res_o.report_terminated      = 1'b1;
          end
        end
        isf_pkg::PhCompleted: begin
          if (item_i.op == isf_pkg::OpInvite) begin
            res_o.accepted             = 1'b1;
            res_o.resend_last_response = 1'b1;
          end else if (item_i.op == isf_pkg::OpAck) begin
            res_o.accepted          = 1'b1;
            res_o.forward_to_dialog = 1'b1;
            tmr_o.absorb_remaining  = cfg_i.unreliable_transport ?
                                      cfg_i.ack_absorb_ms : '0;
            tmr_o.absorb_running    = 1'b1;
          end else if (item_i.op == isf_pkg::OpError) begin
            res_o.accepted               = 1'b1;
            res_o.report_error_to_dialog = 1'b1;
            res_o.report_terminated      = 1'b1;
          end else if (item_i.op == isf_pkg::OpTick) begin
            if (h_fire) begin
              res_o.accepted               = 1'b1;
              res_o.report_error_to_dialog = 1'b1;
              res_o.report_terminated      = 1'b1;
            end else begin
              if (g_fire) begin
                res_o.accepted             = 1'b1;
                res_o.resend_last_response = 1'b1;
                tmr_o.retx_interval        = next_ivl;
                tmr_o.retx_remaining       = next_ivl;
              end else if (tmr_i.retx_running) begin
                tmr_o.retx_remaining = tmr_i.retx_remaining - 16'd1;
              end
              if (tmr_i.giveup_running) begin
                tmr_o.giveup_remaining = tmr_i.giveup_remaining - 16'd1;
              end
            end
          end
        end
        isf_pkg::PhConfirmed: begin
          if (item_i.op == isf_pkg::OpAck) begin
            res_o.accepted = 1'b1;
          end else if (item_i.op == isf_pkg::OpTick) begin
            if (i_fire) begin
              res_o.accepted          = 1'b1;
              res_o.report_terminated = 1'b1;
            end else if (tmr_i.absorb_running) begin
              tmr_o.absorb_remaining = tmr_i.absorb_remaining - 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
    // entering terminated or confirmed stops timers G and H; terminated also stops I
    if (phase_o == isf_pkg::PhTerminated || phase_o == isf_pkg::PhConfirmed) begin
      tmr_o.retx_running     = 1'b0;
      tmr_o.retx_remaining   = '0;
      tmr_o.giveup_running   = 1'b0;
      tmr_o.giveup_remaining = '0;
    end
    if (phase_o == isf_pkg::PhTerminated) begin
      tmr_o.absorb_running   = 1'b0;
      tmr_o.absorb_remaining = '0;
    end
    res_o.phase = phase_o;
  end

endmodule

### hw/rtl/invite_server_transaction_fsm.sv
// ----------------------------------------------------------------------------
// invite_server_transaction_fsm
// Server INVITE transaction control: phase, stored-response flag, timers G/H/I.
// ----------------------------------------------------------------------------
// One event item is taken per cycle while the output is not stalled; each
// yields one result item via the input register, then the result register.
// Phase and timer registers are updated in the single cycle an item moves
// from the input register to the result register, so items may follow back
// to back. Ticks are events: each tick item advances the timers by one
// millisecond. Configuration is always ready and takes effect on the next item.
module invite_server_transaction_fsm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  isf_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output isf_pkg::out_item_t           out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [isf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [isf_pkg::CfgDataW-1:0] cfg_data_i
);

  logic               in_valid_q;
  isf_pkg::in_item_t  in_q;
  logic               out_valid_q, out_valid_d;
  isf_pkg::out_item_t out_q;
  logic               advance;

  isf_pkg::cfg_t      cfg_q, cfg_d;
  isf_pkg::phase_e    phase_q, phase_d;
  isf_pkg::timers_t   tmr_q, tmr_d;
  isf_pkg::out_item_t res;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        isf_pkg::CfgUnreliable: cfg_d.unreliable_transport  = cfg_data_i[0];
        isf_pkg::CfgRetxInit:   cfg_d.retransmit_initial_ms = cfg_data_i;
        isf_pkg::CfgRetxCap:    cfg_d.retransmit_cap_ms     = cfg_data_i;
        isf_pkg::CfgAckWait:    cfg_d.ack_wait_ms           = cfg_data_i;
        isf_pkg::CfgAckAbsorb:  cfg_d.ack_absorb_ms         = cfg_data_i;
        default: ;
      endcase
    end
  end

  isf_step u_step (
    .phase_i (phase_q),
    .tmr_i   (tmr_q),
    .cfg_i   (cfg_q),
    .item_i  (in_q),
    .phase_o (phase_d),
    .tmr_o   (tmr_d),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= isf_pkg::PhStart;
      tmr_q       <= '{have_response: 1'b0, retx_interval: isf_pkg::RetxInitRst,
                       retx_remaining: '0, retx_running: 1'b0,
                       giveup_remaining: '0, giveup_running: 1'b0,
                       absorb_remaining: '0, absorb_running: 1'b0};
      cfg_q       <= '{unreliable_transport: 1'b1,
                       retransmit_initial_ms: isf_pkg::RetxInitRst,
                       retransmit_cap_ms: isf_pkg::RetxCapRst,
                       ack_wait_ms: isf_pkg::AckWaitRst,
                       ack_absorb_ms: isf_pkg::AckAbsorbRst};
    end else begin
      in_valid_q  <= (in_valid_i && !in_stall_o) || in_stall_o;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
      if (advance) begin
        phase_q <= phase_d;
        tmr_q   <= tmr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_item_i;
    if (advance) out_q <= res;
  end

`ifndef SYNTH
  a_term_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == isf_pkg::PhTerminated |=> phase_q == isf_pkg::PhTerminated)
    else $error("left terminated phase");

  a_gh_only_completed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != isf_pkg::PhCompleted |-> !tmr_q.retx_running && !tmr_q.giveup_running)
    else $error("timer G or H running outside completed");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");
`endif

endmodule
